/* src/assert_macros.svh */
// Assertion macros shared by the exception entry unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/mexu_pkg.sv */
// Types and constants of the exception entry unit.
package mexu_pkg;

    typedef enum logic [2:0] {
        MODE_CHECK_IRQ = 3'd0,
        MODE_IRQ_ENTRY = 3'd1,
        MODE_ADDR_ERR  = 3'd2,
        MODE_TLB_MISS  = 3'd3,
        MODE_SYSCALL   = 3'd4,
        MODE_BREAK     = 3'd5,
        MODE_COP_UNUSE = 3'd6
    } exc_mode_t;

    localparam logic [31:0] VEC_GENERAL    = 32'h8000_0180;
    localparam logic [31:0] VEC_TLB_REFILL = 32'h8000_0000;
    localparam logic [31:0] CA_BD          = 32'h8000_0000;
    localparam logic [31:0] CA_IP2         = 32'h0000_0400;
    localparam logic [31:0] CA_CE1         = 32'h1000_0000;
    localparam logic [31:0] ENTRY_HI_MASK  = 32'hFFFF_E000;

    localparam int ST_IE_BIT  = 0;
    localparam int ST_EXL_BIT = 1;
    localparam int ST_ERL_BIT = 2;
    localparam int ST_IM2_BIT = 10;
    localparam int MI_AUDIO_BIT = 2;

    localparam logic [4:0] CODE_INT     = 5'd0;
    localparam logic [4:0] CODE_TLBL    = 5'd2;
    localparam logic [4:0] CODE_ADEL    = 5'd4;
    localparam logic [4:0] CODE_ADES    = 5'd5;
    localparam logic [4:0] CODE_SYSCALL = 5'd8;
    localparam logic [4:0] CODE_BREAK   = 5'd9;
    localparam logic [4:0] CODE_CPU     = 5'd11;

    localparam logic [1:0] COP_ONE = 2'd1;

    localparam logic REG_MI_MASK = 1'b0;
    localparam logic REG_PT_BASE = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic        delay_slot;
        logic [31:0] bad_vaddr;
        logic        from_read;
        logic [1:0]  coprocessor;
        logic        address_mapped;
        logic        audio_intr;
        logic [5:0]  mi_other;
        logic [31:0] cur_pc;
        logic [31:0] status_in;
    } exc_item_t;

    typedef struct packed {
        logic [31:0] cause;
        logic [31:0] epc;
        logic [31:0] bad_addr;
        logic [18:0] ctx_vpn;
        logic [31:0] entry_hi;
        logic        ip2;
    } cop0_state_t;

    typedef struct packed {
        logic        taken;
        logic        irq_request;
        logic [31:0] entry_hi_out;
        logic [31:0] context_out;
        logic [31:0] bad_addr_out;
        logic [31:0] epc_out;
        logic [31:0] cause_out;
        logic [31:0] status_out;
        logic [31:0] next_pc;
    } exc_result_t;

endpackage

/* src/mexu_core.sv */
// Exception entry logic: next COP0 state and result for one event.
module mexu_core
    import mexu_pkg::*;
(
    input  exc_item_t   item,
    input  cop0_state_t state_cur,
    input  logic [5:0]  mi_mask,
    input  logic [8:0]  page_table_base,
    output cop0_state_t state_new,
    output exc_result_t result
);

    logic        enabled;
    logic [31:0] epc_entry;
    logic [31:0] bd_bit;
    logic [5:0]  lines;
    logic        ip2_new;
    logic        enter;
    logic [4:0]  code;
    logic [31:0] extra;
    logic [31:0] npc;
    logic [31:0] status;
    logic        irq;
    logic        taken;

    assign enabled = item.status_in[ST_IE_BIT] & ~item.status_in[ST_EXL_BIT]
                   & ~item.status_in[ST_ERL_BIT];
    assign epc_entry = item.delay_slot ? (item.cur_pc - 32'd4) : item.cur_pc;
    assign bd_bit = item.delay_slot ? CA_BD : 32'd0;
    assign lines = {item.mi_other[5:3], item.audio_intr, item.mi_other[1:0]};
    assign ip2_new = |(lines & mi_mask);

    always_comb
    begin
        state_new = state_cur;
        npc = item.cur_pc;
        status = item.status_in;
        irq = 1'b0;
        taken = 1'b0;
        enter = 1'b0;
        code = CODE_INT;
        extra = 32'd0;
        case (exc_mode_t'(item.mode))
            MODE_CHECK_IRQ:
            begin
                state_new.ip2 = ip2_new;
                irq = enabled & ip2_new & item.status_in[ST_IM2_BIT];
            end
            MODE_IRQ_ENTRY:
            begin
                if (enabled)
                begin
                    enter = 1'b1;
                    code = CODE_INT;
                    extra = state_cur.ip2 ? CA_IP2 : 32'd0;
                end
            end
            MODE_ADDR_ERR:
            begin
                enter = 1'b1;
                code = item.from_read ? CODE_ADEL : CODE_ADES;
                state_new.bad_addr = item.bad_vaddr;
            end
            MODE_TLB_MISS:
            begin
                state_new.bad_addr = item.bad_vaddr;
                state_new.ctx_vpn = item.bad_vaddr[31:13];
                state_new.entry_hi = item.bad_vaddr & ENTRY_HI_MASK;
                code = CODE_TLBL;
                if (!item.status_in[ST_EXL_BIT])
                begin
                    enter = 1'b1;
                end
                else
                begin
                    state_new.cause = {25'd0, CODE_TLBL, 2'b00};
                    taken = 1'b1;
                end
            end
            MODE_SYSCALL:
            begin
                enter = 1'b1;
                code = CODE_SYSCALL;
            end
            MODE_BREAK:
            begin
                enter = 1'b1;
                code = CODE_BREAK;
            end
            MODE_COP_UNUSE:
            begin
                enter = 1'b1;
                code = CODE_CPU;
                extra = (item.coprocessor == COP_ONE) ? CA_CE1 : 32'd0;
            end
            default:
            begin
            end
        endcase

        if (enter)
        begin
            state_new.cause = {25'd0, code, 2'b00} | extra | bd_bit;
            state_new.epc = epc_entry;
            status[ST_EXL_BIT] = 1'b1;
            taken = 1'b1;
        end

        // A nested TLB miss takes the general vector; an unmapped refill takes the refill vector.
        npc = taken ? VEC_GENERAL : item.cur_pc;
        if (enter && (exc_mode_t'(item.mode) == MODE_TLB_MISS) && !item.address_mapped)
        begin
            npc = VEC_TLB_REFILL;
        end
    end

    assign result.next_pc = npc;
    assign result.status_out = status;
    assign result.cause_out = state_new.cause;
    assign result.epc_out = state_new.epc;
    assign result.bad_addr_out = state_new.bad_addr;
    assign result.context_out = {page_table_base, state_new.ctx_vpn, 4'd0};
    assign result.entry_hi_out = state_new.entry_hi;
    assign result.irq_request = irq;
    assign result.taken = taken;

endmodule

/* src/mips_exception_entry_unit.sv */
// Top level of the exception entry unit: stream ports, registers and APB port.
// An input transfer passes through the input register and then the output register.
// Throughput: one item per cycle, limited only by the output being taken.
// The COP0 state is updated as each item leaves the input register.
// Reset (rst_n low, asynchronous) clears the COP0 state, both configuration
// registers and the valid flags of the input and output registers.
`include "assert_macros.svh"

module mips_exception_entry_unit
    import mexu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata, from bit 0: delay_slot, bad_vaddr, from_read, coprocessor,
    // address_mapped, audio_intr, mi_other, cur_pc, status_in, zero fill.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,
    // s_tuser: mode.
    input  logic [2:0]   s_tuser,
    // m_tdata, from bit 0: next_pc, status_out, cause_out, epc_out,
    // bad_addr_out, context_out, entry_hi_out, irq_request, taken, zero fill.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [231:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic        in_valid_reg;
    exc_item_t   in_item_reg;
    cop0_state_t state_reg;
    cop0_state_t state_next;
    logic        out_valid_reg;
    exc_result_t out_data_reg;
    exc_result_t result;
    logic [5:0]  mi_mask_reg;
    logic [8:0]  pt_base_reg;
    logic        advance;
    logic        cfg_write;
    exc_item_t   in_item;

    assign in_item = {s_tuser, s_tdata[0], s_tdata[32:1], s_tdata[33], s_tdata[35:34],
                      s_tdata[36], s_tdata[37], s_tdata[43:38], s_tdata[75:44],
                      s_tdata[107:76]};

    assign advance = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_data_reg};

    assign pready = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_PT_BASE) ? {23'd0, pt_base_reg} : {26'd0, mi_mask_reg};

    mexu_core u_core (
        .item            (in_item_reg),
        .state_cur       (state_reg),
        .mi_mask         (mi_mask_reg),
        .page_table_base (pt_base_reg),
        .state_new       (state_next),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
            mi_mask_reg <= '0;
            pt_base_reg <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                if (paddr[2] == REG_MI_MASK)
                begin
                    mi_mask_reg <= pwdata[5:0];
                end
                else
                begin
                    pt_base_reg <= pwdata[8:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    `ASSERT_IMPL(a_ready_when_out_empty, clk, rst_n, !out_valid_reg, s_tready)
    `ASSERT_NEXT(a_state_holds, clk, rst_n, !advance, $stable(state_reg))
    `ASSERT_IMPL(a_taken_vector, clk, rst_n, out_valid_reg && out_data_reg.taken,
        out_data_reg.next_pc == VEC_GENERAL || out_data_reg.next_pc == VEC_TLB_REFILL)
    `ASSERT_IMPL(a_irq_not_taken, clk, rst_n, out_valid_reg && out_data_reg.irq_request,
        !out_data_reg.taken)

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the exception entry unit: directed and random events, stalls.
module tb_top;
    import mexu_pkg::*;

    localparam logic [2:0] MODE_UNDEFINED = 3'd7;
    localparam logic [2:0] ADDR_MI_MASK   = {REG_MI_MASK, 2'b00};
    localparam logic [2:0] ADDR_PT_BASE   = {REG_PT_BASE, 2'b00};
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_EVENTS = 150;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [231:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    mips_exception_entry_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the COP0 state and configuration, kept in transfer order.
    cop0_state_t cop0 = '0;
    logic [5:0]  mi_mask_shadow = '0;
    logic [8:0]  pt_base_shadow = '0;
    exc_result_t pending_results[$];

    int mismatches = 0;
    int events_sent = 0;
    int results_seen = 0;
    int entries_taken = 0;
    int irqs_raised = 0;
    int settings_used = 1;
    int tx_idle = 0;
    int rx_idle = 0;
    int cycles = 0;
    bit hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("mips_exception_entry_unit: mismatch");
            $finish;
        end
    end

    function automatic int idle_draw(input int level);
        if (level == 0)
            return 0;
        else if (level == 1)
            return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [31:0] enabled_status();
        logic [31:0] st;
        st = $urandom;
        st[ST_IE_BIT] = 1'b1;
        st[ST_EXL_BIT] = 1'b0;
        st[ST_ERL_BIT] = 1'b0;
        st[ST_IM2_BIT] = ($urandom_range(0, 3) != 0);
        return st;
    endfunction

    function automatic exc_item_t random_event();
        exc_item_t it;
        int m;
        m = $urandom_range(0, 19);
        it.mode = (m < 18) ? 3'(m % 7) : MODE_UNDEFINED;
        it.delay_slot = 1'($urandom_range(0, 1));
        it.bad_vaddr = $urandom;
        it.from_read = 1'($urandom_range(0, 1));
        it.coprocessor = 2'($urandom_range(0, 3));
        it.address_mapped = 1'($urandom_range(0, 1));
        it.audio_intr = 1'($urandom_range(0, 1));
        it.mi_other = 6'($urandom_range(0, 63));
        it.cur_pc = $urandom;
        it.status_in = ($urandom_range(0, 1) == 0) ? $urandom : enabled_status();
        return it;
    endfunction

    function automatic exc_item_t pick(input logic [2:0] mode, input logic ds,
                                       input logic [31:0] st, input logic [31:0] pc);
        exc_item_t it;
        it = random_event();
        it.mode = mode;
        it.delay_slot = ds;
        it.status_in = st;
        it.cur_pc = pc;
        return it;
    endfunction

    task automatic enter_exc(input logic [4:0] code, input logic [31:0] extra,
                             input exc_item_t it, inout logic [31:0] st,
                             output logic [31:0] npc);
        cop0.cause = {25'd0, code, 2'b00} | extra;
        if (it.delay_slot)
        begin
            cop0.cause = cop0.cause | CA_BD;
            cop0.epc = it.cur_pc - 32'd4;
        end
        else
        begin
            cop0.epc = it.cur_pc;
        end
        st[ST_EXL_BIT] = 1'b1;
        npc = VEC_GENERAL;
    endtask

    task automatic predict_exception(input exc_item_t it);
        exc_result_t r;
        logic [31:0] st;
        logic [31:0] npc;
        logic [5:0]  lines;
        logic        en;
        r = '0;
        st = it.status_in;
        npc = it.cur_pc;
        en = st[ST_IE_BIT] && !st[ST_EXL_BIT] && !st[ST_ERL_BIT];
        case (it.mode)
            MODE_CHECK_IRQ:
            begin
                lines = it.mi_other;
                lines[MI_AUDIO_BIT] = it.audio_intr;
                cop0.ip2 = |(lines & mi_mask_shadow);
                r.irq_request = en && cop0.ip2 && st[ST_IM2_BIT];
            end
            MODE_IRQ_ENTRY:
            begin
                if (en)
                begin
                    enter_exc(CODE_INT, cop0.ip2 ? CA_IP2 : 32'd0, it, st, npc);
                    r.taken = 1'b1;
                end
            end
            MODE_ADDR_ERR:
            begin
                enter_exc(it.from_read ? CODE_ADEL : CODE_ADES, 32'd0, it, st, npc);
                cop0.bad_addr = it.bad_vaddr;
                r.taken = 1'b1;
            end
            MODE_TLB_MISS:
            begin
                cop0.cause = {25'd0, CODE_TLBL, 2'b00};
                cop0.bad_addr = it.bad_vaddr;
                cop0.ctx_vpn = it.bad_vaddr[31:13];
                cop0.entry_hi = it.bad_vaddr & ENTRY_HI_MASK;
                if (!st[ST_EXL_BIT])
                begin
                    enter_exc(CODE_TLBL, 32'd0, it, st, npc);
                    npc = it.address_mapped ? VEC_GENERAL : VEC_TLB_REFILL;
                end
                else
                begin
                    npc = VEC_GENERAL;
                end
                r.taken = 1'b1;
            end
            MODE_SYSCALL:
            begin
                enter_exc(CODE_SYSCALL, 32'd0, it, st, npc);
                r.taken = 1'b1;
            end
            MODE_BREAK:
            begin
                enter_exc(CODE_BREAK, 32'd0, it, st, npc);
                r.taken = 1'b1;
            end
            MODE_COP_UNUSE:
            begin
                enter_exc(CODE_CPU, (it.coprocessor == COP_ONE) ? CA_CE1 : 32'd0, it, st, npc);
                r.taken = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.next_pc = npc;
        r.status_out = st;
        r.cause_out = cop0.cause;
        r.epc_out = cop0.epc;
        r.bad_addr_out = cop0.bad_addr;
        r.context_out = {pt_base_shadow, cop0.ctx_vpn, 4'b0000};
        r.entry_hi_out = cop0.entry_hi;
        entries_taken += int'(r.taken);
        irqs_raised += int'(r.irq_request);
        pending_results.push_back(r);
    endtask

    task automatic send_event(input exc_item_t it);
        int gap;
        gap = idle_draw(tx_idle);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {4'b0000, it.status_in, it.cur_pc, it.mi_other, it.audio_intr,
                    it.address_mapped, it.coprocessor, it.from_read, it.bad_vaddr,
                    it.delay_slot};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_exception(it);
        events_sent++;
    endtask

    // Stops the stream and waits until every predicted result has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_MI_MASK)
            mi_mask_shadow = data[5:0];
        else
            pt_base_shadow = data[8:0];
    endtask

    task automatic set_config(input logic [5:0] mask, input logic [8:0] base);
        apb_write(ADDR_MI_MASK, {26'd0, mask});
        apb_write(ADDR_PT_BASE, {23'd0, base});
        settings_used++;
    endtask

    // Receiver: a random stall before each transfer, plus an optional long hold-off.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = idle_draw(rx_idle);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid && !hold_req);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        exc_result_t got;
        exc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = exc_result_t'(m_tdata[225:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("next_pc", want.next_pc, got.next_pc);
                check_field("status_out", want.status_out, got.status_out);
                check_field("cause_out", want.cause_out, got.cause_out);
                check_field("epc_out", want.epc_out, got.epc_out);
                check_field("bad_addr_out", want.bad_addr_out, got.bad_addr_out);
                check_field("context_out", want.context_out, got.context_out);
                check_field("entry_hi_out", want.entry_hi_out, got.entry_hi_out);
                check_field("irq_request", 32'(want.irq_request), 32'(got.irq_request));
                check_field("taken", 32'(want.taken), 32'(got.taken));
                check_field("zero fill", 32'd0, 32'(m_tdata[231:226]));
            end
            results_seen++;
        end
    end

    task automatic test_reset_values();
        send_event(pick(MODE_UNDEFINED, 1'b0, $urandom, $urandom));
        send_event(pick(MODE_CHECK_IRQ, 1'b0, enabled_status(), $urandom));
        drain();
    endtask

    task automatic test_directed_events();
        exc_item_t it;
        logic [31:0] en_st;
        set_config(6'h3F, 9'h1FF);
        en_st = enabled_status();
        en_st[ST_IM2_BIT] = 1'b1;
        it = pick(MODE_CHECK_IRQ, 1'b0, en_st, $urandom);
        it.audio_intr = 1'b1;
        it.mi_other = 6'h00;
        send_event(it);
        send_event(pick(MODE_IRQ_ENTRY, 1'b0, en_st, 32'hFFFF_FFFF));
        // Audio line replaces bit 2 of the controller lines.
        it = pick(MODE_CHECK_IRQ, 1'b0, en_st, $urandom);
        it.audio_intr = 1'b0;
        it.mi_other = 6'h04;
        send_event(it);
        send_event(pick(MODE_IRQ_ENTRY, 1'b1, en_st, 32'h0000_0000));
        send_event(pick(MODE_IRQ_ENTRY, 1'b0, en_st & ~32'h1, $urandom));
        send_event(pick(MODE_IRQ_ENTRY, 1'b1, en_st | 32'h2, $urandom));
        send_event(pick(MODE_IRQ_ENTRY, 1'b0, en_st | 32'h4, $urandom));
        it = pick(MODE_CHECK_IRQ, 1'b0, en_st & ~CA_IP2, $urandom);
        it.mi_other = 6'h3F;
        send_event(it);
        it = pick(MODE_CHECK_IRQ, 1'b0, 32'hFFFF_FFFF, $urandom);
        it.mi_other = 6'h3F;
        it.audio_intr = 1'b1;
        send_event(it);
        it = pick(MODE_ADDR_ERR, 1'b0, 32'd0, 32'hFFFF_FFFF);
        it.from_read = 1'b1;
        it.bad_vaddr = 32'hFFFF_FFFF;
        send_event(it);
        it = pick(MODE_ADDR_ERR, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        it.from_read = 1'b0;
        it.bad_vaddr = 32'h0000_0000;
        send_event(it);
        it = pick(MODE_TLB_MISS, 1'b0, en_st, $urandom);
        it.address_mapped = 1'b0;
        it.bad_vaddr = 32'hFFFF_FFFF;
        send_event(it);
        it = pick(MODE_TLB_MISS, 1'b1, en_st, 32'h0000_0002);
        it.address_mapped = 1'b1;
        it.bad_vaddr = 32'h0000_0000;
        send_event(it);
        // Nested miss: EXL already set keeps the return address.
        it = pick(MODE_TLB_MISS, 1'b1, en_st | 32'h2, $urandom);
        it.address_mapped = 1'b0;
        send_event(it);
        send_event(pick(MODE_SYSCALL, 1'b0, 32'hFFFF_FFFF, $urandom));
        send_event(pick(MODE_BREAK, 1'b1, 32'h0000_0000, $urandom));
        for (int c = 0; c < 4; c++)
        begin
            it = pick(MODE_COP_UNUSE, c[0], $urandom, $urandom);
            it.coprocessor = 2'(c);
            send_event(it);
        end
        send_event(pick(MODE_UNDEFINED, 1'b1, $urandom, $urandom));
        drain();
    endtask

    task automatic test_config_sweep();
        exc_item_t it;
        int n;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_config(6'h00, 9'h000);
                1: set_config(6'h3F, 9'h1FF);
                2: set_config(6'h04, 9'($urandom_range(0, 511)));
                3: set_config(6'($urandom_range(0, 63)), 9'($urandom_range(0, 511)));
                default: set_config(6'h3B, 9'($urandom_range(0, 511)));
            endcase
            n = 0;
            while (n < PHASE_EVENTS)
            begin
                if (n % 50 == 0)
                begin
                    tx_idle = $urandom_range(0, 2);
                    rx_idle = $urandom_range(0, 2);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        it = random_event();
                        it.mode = MODE_CHECK_IRQ;
                        it.status_in = enabled_status();
                        send_event(it);
                        it = random_event();
                        it.mode = MODE_IRQ_ENTRY;
                        it.status_in = ($urandom_range(0, 4) != 0) ? enabled_status() : $urandom;
                        send_event(it);
                        n += 2;
                    end
                    4, 5:
                    begin
                        it = random_event();
                        it.mode = MODE_TLB_MISS;
                        it.status_in = enabled_status();
                        send_event(it);
                        it = random_event();
                        it.mode = ($urandom_range(0, 1) == 0) ? MODE_TLB_MISS : MODE_ADDR_ERR;
                        it.status_in = enabled_status() | 32'h2;
                        send_event(it);
                        n += 2;
                    end
                    default:
                    begin
                        send_event(random_event());
                        n += 1;
                    end
                endcase
            end
            drain();
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        hold_req = 1'b1;
        repeat (30) send_event(random_event());
        drain();
        tx_idle = 2;
        rx_idle = 2;
        repeat (20) send_event(random_event());
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_events();
        test_config_sweep();
        test_output_backpressure();
        $display("Sent %0d exception events under %0d register settings; %0d results checked.",
                 events_sent, settings_used, results_seen);
        $display("Exceptions entered: %0d, interrupt requests raised: %0d.",
                 entries_taken, irqs_raised);
        if (mismatches == 0)
        begin
            $display("mips_exception_entry_unit: match");
        end
        else
        begin
            $display("mips_exception_entry_unit: mismatch");
        end
        $finish;
    end

endmodule

/* mips_exception_entry_unit.f */
+incdir+src
src/mexu_pkg.sv
src/mexu_core.sv
src/mips_exception_entry_unit.sv
tb/sv/tb_top.sv
